@@ rtl/swps_pkg.sv @@
// ----------------------------------------------------------------------------
// swps_pkg
// Shared constants and helpers for the single-wire pulse-width sender.
// ----------------------------------------------------------------------------
`default_nettype none

package swps_pkg;

  // Longest fields the bus supports
  localparam int unsigned MaxAddressBits = 8;
  localparam int unsigned MaxDataBits    = 8;

  // Width of a clamped length (holds the largest maximum)
  localparam int unsigned LenW = 5;

  // Segment lengths in time units
  localparam logic [4:0] StartLowUnits  = 5'd18;
  localparam logic [4:0] StartHighUnits = 5'd2;
  localparam logic [4:0] LongUnits      = 5'd8;
  localparam logic [4:0] ShortUnits     = 5'd2;
  localparam logic [4:0] AckLowUnits    = 5'd2;
  localparam logic [4:0] AckSampleUnits = 5'd3;
  localparam logic [4:0] AckWaitUnits   = 5'd5;

  // Register reset values
  localparam logic [3:0] AddrLenReset = 4'd5;
  localparam logic [3:0] DataLenReset = 4'd1;

  // Register indexes
  localparam logic RegAddrLen = 1'b0;
  localparam logic RegDataLen = 1'b1;

  // Transfer status codes
  localparam logic [1:0] OutcomeOk       = 2'd0;
  localparam logic [1:0] OutcomeAddrNack = 2'd1;
  localparam logic [1:0] OutcomeDataNack = 2'd2;

  // Length register to effective bit count: zero acts as one, cap at maximum
  function automatic logic [LenW-1:0] clamp_len(input logic [3:0] v,
                                                input logic [LenW-1:0] maxv);
    logic [LenW-1:0] ext;
    ext = {{(LenW-4){1'b0}}, v};
    if (ext == '0) begin
      return {{(LenW-1){1'b0}}, 1'b1};
    end else if (ext > maxv) begin
      return maxv;
    end else begin
      return ext;
    end
  endfunction

endpackage

`default_nettype wire

@@ rtl/swps_if.sv @@
// ----------------------------------------------------------------------------
// swps_if
// Valid/ready channels of the single-wire pulse-width sender.
// ----------------------------------------------------------------------------
`default_nettype none

// Command/tick channel
interface swps_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic       line_level;
  logic [7:0] target_address;
  logic [7:0] payload;

  modport source (output valid, command, line_level, target_address, payload,
                  input ready);
  modport sink   (input valid, command, line_level, target_address, payload,
                  output ready);
endinterface

// Result channel
interface swps_out_if;
  logic       valid;
  logic       ready;
  logic       pull_low;
  logic       busy_res;
  logic       finished;
  logic [1:0] outcome;
  logic       refused;

  modport source (output valid, pull_low, busy_res, finished, outcome, refused,
                  input ready);
  modport sink   (input valid, pull_low, busy_res, finished, outcome, refused,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/single_wire_pulse_width_sender.sv @@
// ----------------------------------------------------------------------------
// single_wire_pulse_width_sender
// Master side of an open-drain single-wire bus, paced by time-unit ticks.
//
// Each transfer on in_i is either a tick (command 0) or a start command
// (command 1, with target_address and payload). Every input transfer yields
// exactly one result transfer on out_o: pull_low is the drive level for the
// coming unit, busy_res tells whether a frame is running, finished/outcome
// report the end of a frame, refused flags a start that came while busy.
// An input transfer passes the input register and then the result register
// before its result is valid. Throughput is one item per cycle unless out_o
// stalls; the sequencer step is a single pass of counter and phase logic.
// The result register lets the next item be taken while a result waits.
// When out_o stalls, the input register holds one more item, then in_i
// ready drops. Reset clears both stages and returns the line to released.
// The APB port holds address_length (0x0) and data_length (0x4); write them
// only while no frame is running.
// ----------------------------------------------------------------------------
`default_nettype none

module single_wire_pulse_width_sender
  import swps_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  swps_in_if.sink          in_i,
  swps_out_if.source       out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  // Sequencer phase codes
  localparam logic [3:0] PhIdle       = 4'd0;
  localparam logic [3:0] PhStartLow   = 4'd1;
  localparam logic [3:0] PhStartHigh  = 4'd2;
  localparam logic [3:0] PhAbitLow    = 4'd3;
  localparam logic [3:0] PhAbitHigh   = 4'd4;
  localparam logic [3:0] PhAackLow    = 4'd5;
  localparam logic [3:0] PhAackSample = 4'd6;
  localparam logic [3:0] PhAackWait   = 4'd7;
  localparam logic [3:0] PhDbitLow    = 4'd8;
  localparam logic [3:0] PhDbitHigh   = 4'd9;
  localparam logic [3:0] PhDackLow    = 4'd10;
  localparam logic [3:0] PhDackSample = 4'd11;
  localparam logic [3:0] PhDackWait   = 4'd12;

  localparam logic [LenW-1:0] MaxAddrLen = LenW'(MaxAddressBits);
  localparam logic [LenW-1:0] MaxDataLen = LenW'(MaxDataBits);

  // Configuration registers
  logic [3:0] addr_len_q;
  logic [3:0] data_len_q;
  logic       cfg_wr;

  // Input stage
  logic       in_vld_q;
  logic       in_cmd_q;
  logic       in_lvl_q;
  logic [7:0] in_addr_q;
  logic [7:0] in_data_q;
  logic       advance;

  // Sequencer state
  logic [3:0] phase_q, phase_d;
  logic [4:0] unit_q, unit_d;
  logic [3:0] bit_idx_q, bit_idx_d;
  logic [7:0] addr_sh_q, addr_sh_d;
  logic [7:0] data_sh_q, data_sh_d;
  logic       pulled_q, pulled_d;

  // Result stage
  logic       out_vld_q;
  logic       res_fin_d, res_fin_q;
  logic [1:0] res_outc_d, res_outc_q;
  logic       res_ref_d, res_ref_q;
  logic       res_pull_q;
  logic       res_busy_q;

  // Step helpers
  logic [4:0] seg_len;
  logic [4:0] unit_inc;
  logic       seg_done;
  logic [3:0] nidx;

  // ---------------------------------------------------------------- APB port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_len_q <= AddrLenReset;
      data_len_q <= DataLenReset;
    end else if (cfg_wr) begin
      case (paddr[2])
        RegAddrLen: addr_len_q <= pwdata[3:0];
        RegDataLen: data_len_q <= pwdata[3:0];
        default:    addr_len_q <= addr_len_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegAddrLen: prdata = {28'd0, addr_len_q};
      RegDataLen: prdata = {28'd0, data_len_q};
      default:    prdata = '0;
    endcase
  end

  // ------------------------------------------------------------ handshakes
  assign advance    = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_cmd_q  <= in_i.command;
      in_lvl_q  <= in_i.line_level;
      in_addr_q <= in_i.target_address;
      in_data_q <= in_i.payload;
    end
  end

  // ---------------------------------------------------------- segment length
  always_comb begin
    case (phase_q)
      PhStartLow:   seg_len = StartLowUnits;
      PhStartHigh:  seg_len = StartHighUnits;
      PhAbitLow:    seg_len = addr_sh_q[0] ? LongUnits : ShortUnits;
      PhAbitHigh:   seg_len = addr_sh_q[0] ? ShortUnits : LongUnits;
      PhDbitLow:    seg_len = data_sh_q[0] ? LongUnits : ShortUnits;
      PhDbitHigh:   seg_len = data_sh_q[0] ? ShortUnits : LongUnits;
      PhAackLow,
      PhDackLow:    seg_len = AckLowUnits;
      PhAackSample,
      PhDackSample: seg_len = AckSampleUnits;
      PhAackWait,
      PhDackWait:   seg_len = AckWaitUnits;
      default:      seg_len = 5'd1;
    endcase
  end

  assign unit_inc = unit_q + 5'd1;
  assign seg_done = unit_inc >= seg_len;
  assign nidx     = bit_idx_q + 4'd1;

  // ------------------------------------------------------------- sequencer
  always_comb begin
    phase_d    = phase_q;
    unit_d     = unit_q;
    bit_idx_d  = bit_idx_q;
    addr_sh_d  = addr_sh_q;
    data_sh_d  = data_sh_q;
    pulled_d   = pulled_q;
    res_fin_d  = 1'b0;
    res_outc_d = OutcomeOk;
    res_ref_d  = 1'b0;

    if (in_cmd_q) begin
      // Start: refused while a frame runs, else load and pull low
      if (phase_q != PhIdle) begin
        res_ref_d = 1'b1;
      end else begin
        addr_sh_d = in_addr_q;
        data_sh_d = in_data_q;
        bit_idx_d = '0;
        phase_d   = PhStartLow;
        pulled_d  = 1'b1;
        unit_d    = '0;
      end
    end else if (phase_q != PhIdle) begin
      // Tick: count one unit, move on at the end of a segment
      unit_d = unit_inc;
      if (seg_done) begin
        unit_d = '0;
        case (phase_q)
          PhStartLow: begin
            phase_d  = PhStartHigh;
            pulled_d = 1'b0;
          end
          PhStartHigh: begin
            bit_idx_d = '0;
            phase_d   = PhAbitLow;
            pulled_d  = 1'b1;
          end
          PhAbitLow: begin
            phase_d  = PhAbitHigh;
            pulled_d = 1'b0;
          end
          PhAbitHigh: begin
            addr_sh_d = {1'b0, addr_sh_q[7:1]};
            pulled_d  = 1'b1;
            if (({1'b0, nidx} >= clamp_len(addr_len_q, MaxAddrLen)) || nidx == '0) begin
              bit_idx_d = '0;
              phase_d   = PhAackLow;
            end else begin
              bit_idx_d = nidx;
              phase_d   = PhAbitLow;
            end
          end
          PhAackLow: begin
            phase_d  = PhAackSample;
            pulled_d = 1'b0;
          end
          PhAackSample: begin
            pulled_d = 1'b0;
            if (in_lvl_q) begin
              res_fin_d  = 1'b1;
              res_outc_d = OutcomeAddrNack;
              phase_d    = PhIdle;
            end else begin
              phase_d = PhAackWait;
            end
          end
          PhAackWait: begin
            bit_idx_d = '0;
            phase_d   = PhDbitLow;
            pulled_d  = 1'b1;
          end
          PhDbitLow: begin
            phase_d  = PhDbitHigh;
            pulled_d = 1'b0;
          end
          PhDbitHigh: begin
            data_sh_d = {1'b0, data_sh_q[7:1]};
            pulled_d  = 1'b1;
            if (({1'b0, nidx} >= clamp_len(data_len_q, MaxDataLen)) || nidx == '0) begin
              bit_idx_d = '0;
              phase_d   = PhDackLow;
            end else begin
              bit_idx_d = nidx;
              phase_d   = PhDbitLow;
            end
          end
          PhDackLow: begin
            phase_d  = PhDackSample;
            pulled_d = 1'b0;
          end
          PhDackSample: begin
            pulled_d = 1'b0;
            if (in_lvl_q) begin
              res_fin_d  = 1'b1;
              res_outc_d = OutcomeDataNack;
              phase_d    = PhIdle;
            end else begin
              phase_d = PhDackWait;
            end
          end
          PhDackWait: begin
            res_fin_d  = 1'b1;
            res_outc_d = OutcomeOk;
            phase_d    = PhIdle;
            pulled_d   = 1'b0;
          end
          default: begin
            phase_d  = PhIdle;
            pulled_d = 1'b0;
          end
        endcase
      end
    end
  end

  // Sequencer state, updated once per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      unit_q    <= '0;
      bit_idx_q <= '0;
      addr_sh_q <= '0;
      data_sh_q <= '0;
      pulled_q  <= 1'b0;
    end else if (advance) begin
      phase_q   <= phase_d;
      unit_q    <= unit_d;
      bit_idx_q <= bit_idx_d;
      addr_sh_q <= addr_sh_d;
      data_sh_q <= data_sh_d;
      pulled_q  <= pulled_d;
    end
  end

  // ---------------------------------------------------------- result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_pull_q <= pulled_d;
      res_busy_q <= (phase_d != PhIdle);
      res_fin_q  <= res_fin_d;
      res_outc_q <= res_outc_d;
      res_ref_q  <= res_ref_d;
    end
  end

  assign out_o.valid    = out_vld_q;
  assign out_o.pull_low = res_pull_q;
  assign out_o.busy_res = res_busy_q;
  assign out_o.finished = res_fin_q;
  assign out_o.outcome  = res_outc_q;
  assign out_o.refused  = res_ref_q;

endmodule

`default_nettype wire
